// File: design/edf_tick_scheduler_unit_assert.svh
// Assertion macros shared by the scheduler checkers
`ifndef EDF_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define EDF_TICK_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define EDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low
`define EDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/edf_pkg.sv
// Types, constants and helpers shared by the EDF tick scheduler
package edf_pkg;

  localparam int SLOT_W       = 3;
  localparam int TIME_FIELD_W = 16;
  localparam int COUNT_W      = 16;
  localparam int MASK_W       = 8;
  localparam int CFG_W        = 4;
  localparam int REQ_W        = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  run_slot;
    logic               idle;
    logic               finished;
    logic [MASK_W-1:0]  lost_mask;
    logic [COUNT_W-1:0] lost_total;
    logic [COUNT_W-1:0] done_total;
    logic [COUNT_W-1:0] burst_left;
  } result_t;

  // write enables into the task file
  typedef struct packed {
    logic tables;
    logic burst;
    logic countdown;
    logic lost;
    logic done;
  } tf_we_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// File: design/edf_if.sv
// Valid/ready channel interfaces for the scheduler request and result beats
interface edf_in_if;
  logic                            valid;
  logic                            ready;
  logic [edf_pkg::REQ_W-1:0]       req_type;
  logic [edf_pkg::SLOT_W-1:0]      task_slot;
  logic [edf_pkg::TIME_FIELD_W-1:0] task_period;
  logic [edf_pkg::TIME_FIELD_W-1:0] task_burst;

  modport source (output valid, req_type, task_slot, task_period, task_burst,
                  input ready);
  modport sink   (input valid, req_type, task_slot, task_period, task_burst,
                  output ready);
endinterface

interface edf_out_if;
  logic                         valid;
  logic                         ready;
  logic [edf_pkg::SLOT_W-1:0]   run_slot;
  logic                         idle;
  logic                         finished;
  logic [edf_pkg::MASK_W-1:0]   lost_mask;
  logic [edf_pkg::COUNT_W-1:0]  lost_total;
  logic [edf_pkg::COUNT_W-1:0]  done_total;
  logic [edf_pkg::COUNT_W-1:0]  burst_left;

  modport source (output valid, run_slot, idle, finished, lost_mask, lost_total,
                  done_total, burst_left, input ready);
  modport sink   (input valid, run_slot, idle, finished, lost_mask, lost_total,
                  done_total, burst_left, output ready);
endinterface

// File: design/edf_tick_scheduler_unit.sv
// Top level of the earliest-deadline-first tick scheduler
//
// Requests arrive as beats on in_ch (valid/ready): write a task slot, advance
// one tick, or read a slot's statistics. Every request gives exactly one
// result beat on out_ch. cfg_we/cfg_wdata set the number of slots in use and
// the user must write them only while the block is idle; the block does not enforce this.
// A write or read passes through its WRITE or READ state and then DONE before
// the result register takes its result; a tick passes through SCAN, which
// visits each slot in use, then FINISH and DONE. A new request is taken only
// once DONE has handed on the previous result, which waits while out_ch stalls.
// The tick time is set by the slot scan: one shared compare/release unit
// visits one slot per cycle through a single-port task file, in circular
// order from the slot last run; a closing SCAN step, FINISH, which updates
// the winner, and DONE, which hands the beat to the result register, follow.
// One request is in flight at a time; in_ch.ready is high only when idle.
// The result register lets a new request be taken while the previous result
// waits; if out_ch stalls, a finished request holds until the register frees.
// Reset (synchronous, rst_n low) clears all bursts, countdowns and counters,
// sets the slot count to 1 and the last-run slot to 0; period and burst
// tables stay undefined until written.
module edf_tick_scheduler_unit #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  edf_in_if.sink                    in_ch,
  edf_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [edf_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_TASKS);

  // sequencer state
  edf_pkg::state_t state_r, state_nxt;

  // latched request
  logic [edf_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [TIME_BITS-1:0]       period_r, period_nxt;
  logic [TIME_BITS-1:0]       burst_r, burst_nxt;

  // scheduler state and scan registers
  logic [edf_pkg::CFG_W-1:0]  task_count_r, task_count_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [IDX_W-1:0]           q_r, q_nxt;
  logic                       found_r, found_nxt;
  logic [IDX_W-1:0]           best_r, best_nxt;
  logic [TIME_BITS-1:0]       best_dl_r, best_dl_nxt;
  logic [IDX_W-1:0]           last_run_r, last_run_nxt;
  logic                       past_first_r, past_first_nxt;

  // result being built, and the output register
  edf_pkg::result_t           res_r, res_nxt;
  edf_pkg::result_t           out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // task file port
  logic [IDX_W-1:0]            tf_addr;
  edf_pkg::tf_we_t             tf_we;
  logic [TIME_BITS-1:0]        tf_wr_period, tf_wr_reload, tf_wr_burst, tf_wr_countdown;
  logic [edf_pkg::COUNT_W-1:0] tf_wr_lost, tf_wr_done;
  logic [TIME_BITS-1:0]        tf_rd_period, tf_rd_reload, tf_rd_burst, tf_rd_countdown;
  logic [edf_pkg::COUNT_W-1:0] tf_rd_lost, tf_rd_done;

  // shared slot unit
  logic [TIME_BITS-1:0] alu_burst, alu_dl_sel, alu_countdown;
  logic                 alu_lost, alu_better;

  logic             in_accept;
  logic             out_free;
  logic             slot_ok;
  logic             scan_active;
  logic [CNT_W-1:0] n_req;
  logic [IDX_W-1:0] q_start;

  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign slot_ok     = int'(slot_r) < MAX_TASKS;
  assign scan_active = (cnt_r != n_r);

  // slots in use saturate at MAX_TASKS; scan starts at last run if still in use
  assign n_req   = (int'(task_count_r) > MAX_TASKS) ? N_MAX : CNT_W'(task_count_r);
  assign q_start = (CNT_W'(last_run_r) < n_req) ? last_run_r : '0;

  edf_task_file #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_task_file (
    .clk          (clk),
    .rst_n        (rst_n),
    .addr         (tf_addr),
    .we           (tf_we),
    .wr_period    (tf_wr_period),
    .wr_reload    (tf_wr_reload),
    .wr_burst     (tf_wr_burst),
    .wr_countdown (tf_wr_countdown),
    .wr_lost      (tf_wr_lost),
    .wr_done      (tf_wr_done),
    .rd_period    (tf_rd_period),
    .rd_reload    (tf_rd_reload),
    .rd_burst     (tf_rd_burst),
    .rd_countdown (tf_rd_countdown),
    .rd_lost      (tf_rd_lost),
    .rd_done      (tf_rd_done)
  );

  edf_slot_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_slot_alu (
    .past_first    (past_first_r),
    .burst         (tf_rd_burst),
    .countdown     (tf_rd_countdown),
    .period        (tf_rd_period),
    .reload        (tf_rd_reload),
    .found         (found_r),
    .best_dl       (best_dl_r),
    .burst_out     (alu_burst),
    .countdown_sel (alu_dl_sel),
    .countdown_out (alu_countdown),
    .lost          (alu_lost),
    .better        (alu_better)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edf_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (edf_pkg::req_t'(in_ch.req_type))
            edf_pkg::REQ_WRITE: state_nxt = edf_pkg::ST_WRITE;
            edf_pkg::REQ_TICK:  state_nxt = edf_pkg::ST_SCAN;
            edf_pkg::REQ_READ:  state_nxt = edf_pkg::ST_READ;
            default:            state_nxt = edf_pkg::ST_DONE;
          endcase
        end
      end
      edf_pkg::ST_WRITE:  state_nxt = edf_pkg::ST_DONE;
      edf_pkg::ST_READ:   state_nxt = edf_pkg::ST_DONE;
      edf_pkg::ST_SCAN: begin
        if (!scan_active) state_nxt = edf_pkg::ST_FINISH;
      end
      edf_pkg::ST_FINISH: state_nxt = edf_pkg::ST_DONE;
      edf_pkg::ST_DONE: begin
        if (out_free) state_nxt = edf_pkg::ST_IDLE;
      end
    endcase
  end

  // task file control
  always_comb begin
    tf_addr         = q_r;
    tf_we           = '0;
    tf_wr_period    = '0;
    tf_wr_reload    = '0;
    tf_wr_burst     = '0;
    tf_wr_countdown = '0;
    tf_wr_lost      = '0;
    tf_wr_done      = '0;
    unique case (state_r)
      edf_pkg::ST_WRITE: begin
        tf_addr = slot_ok ? IDX_W'(slot_r) : '0;
        if (slot_ok) begin
          // zero period is stored as one
          tf_wr_period    = (period_r == '0) ? TIME_BITS'(1) : period_r;
          tf_wr_reload    = burst_r;
          tf_wr_burst     = burst_r;
          tf_wr_countdown = tf_wr_period;
          tf_we.tables    = 1'b1;
          tf_we.burst     = 1'b1;
          tf_we.countdown = 1'b1;
        end
      end
      edf_pkg::ST_READ: begin
        tf_addr = slot_ok ? IDX_W'(slot_r) : '0;
      end
      edf_pkg::ST_SCAN: begin
        tf_addr = q_r;
        if (scan_active) begin
          tf_wr_burst     = alu_burst;
          tf_wr_countdown = alu_countdown;
          tf_wr_lost      = edf_pkg::sat_inc(tf_rd_lost);
          tf_we.burst     = 1'b1;
          tf_we.countdown = 1'b1;
          tf_we.lost      = alu_lost;
        end
      end
      edf_pkg::ST_FINISH: begin
        tf_addr = best_r;
        if (found_r) begin
          tf_wr_burst = tf_rd_burst - 1'b1;
          tf_wr_done  = edf_pkg::sat_inc(tf_rd_done);
          tf_we.burst = 1'b1;
          tf_we.done  = (tf_rd_burst == TIME_BITS'(1));
        end
      end
      edf_pkg::ST_IDLE, edf_pkg::ST_DONE: begin
        tf_addr = q_r;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    slot_nxt       = slot_r;
    period_nxt     = period_r;
    burst_nxt      = burst_r;
    task_count_nxt = cfg_we ? cfg_wdata : task_count_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    q_nxt          = q_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_dl_nxt    = best_dl_r;
    last_run_nxt   = last_run_r;
    past_first_nxt = past_first_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      edf_pkg::ST_IDLE: begin
        if (in_accept) begin
          slot_nxt   = in_ch.task_slot;
          period_nxt = TIME_BITS'(in_ch.task_period);
          burst_nxt  = TIME_BITS'(in_ch.task_burst);
          n_nxt      = n_req;
          cnt_nxt    = '0;
          q_nxt      = q_start;
          found_nxt  = 1'b0;
          res_nxt    = '0;
        end
      end
      edf_pkg::ST_READ: begin
        if (slot_ok) begin
          res_nxt.lost_total = tf_rd_lost;
          res_nxt.done_total = tf_rd_done;
          res_nxt.burst_left = edf_pkg::COUNT_W'(tf_rd_burst);
        end
      end
      edf_pkg::ST_SCAN: begin
        if (scan_active) begin
          if (alu_better) begin
            found_nxt   = 1'b1;
            best_nxt    = q_r;
            best_dl_nxt = alu_dl_sel;
          end
          for (int i = 0; i < edf_pkg::MASK_W; i++) begin
            if (alu_lost && (int'(q_r) == i)) res_nxt.lost_mask[i] = 1'b1;
          end
          cnt_nxt = cnt_r + 1'b1;
          q_nxt   = ((CNT_W'(q_r) + 1'b1) >= n_r) ? '0 : q_r + 1'b1;
        end
      end
      edf_pkg::ST_FINISH: begin
        past_first_nxt = 1'b1;
        if (found_r) begin
          last_run_nxt     = best_r;
          res_nxt.run_slot = edf_pkg::SLOT_W'(best_r);
          res_nxt.finished = (tf_rd_burst == TIME_BITS'(1));
        end else begin
          res_nxt.idle = 1'b1;
        end
      end
      edf_pkg::ST_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      edf_pkg::ST_WRITE: begin
        res_nxt = res_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= edf_pkg::ST_IDLE;
      task_count_r <= edf_pkg::CFG_W'(1);
      last_run_r   <= '0;
      past_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      cnt_r        <= '0;
      n_r          <= '0;
      q_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      last_run_r   <= last_run_nxt;
      past_first_r <= past_first_nxt;
      out_valid_r  <= out_valid_nxt;
      found_r      <= found_nxt;
      cnt_r        <= cnt_nxt;
      n_r          <= n_nxt;
      q_r          <= q_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    period_r  <= period_nxt;
    burst_r   <= burst_nxt;
    best_r    <= best_nxt;
    best_dl_r <= best_dl_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_ch.ready       = (state_r == edf_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.run_slot   = out_r.run_slot;
  assign out_ch.idle       = out_r.idle;
  assign out_ch.finished   = out_r.finished;
  assign out_ch.lost_mask  = out_r.lost_mask;
  assign out_ch.lost_total = out_r.lost_total;
  assign out_ch.done_total = out_r.done_total;
  assign out_ch.burst_left = out_r.burst_left;

endmodule

// File: design/edf_task_file.sv
// Per-slot task state, one address per cycle, combinational read
module edf_task_file #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 16,
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [IDX_W-1:0]               addr,
  input  edf_pkg::tf_we_t                we,
  input  logic [TIME_BITS-1:0]           wr_period,
  input  logic [TIME_BITS-1:0]           wr_reload,
  input  logic [TIME_BITS-1:0]           wr_burst,
  input  logic [TIME_BITS-1:0]           wr_countdown,
  input  logic [edf_pkg::COUNT_W-1:0]    wr_lost,
  input  logic [edf_pkg::COUNT_W-1:0]    wr_done,
  output logic [TIME_BITS-1:0]           rd_period,
  output logic [TIME_BITS-1:0]           rd_reload,
  output logic [TIME_BITS-1:0]           rd_burst,
  output logic [TIME_BITS-1:0]           rd_countdown,
  output logic [edf_pkg::COUNT_W-1:0]    rd_lost,
  output logic [edf_pkg::COUNT_W-1:0]    rd_done
);

  logic [TIME_BITS-1:0]        period_r    [MAX_TASKS];
  logic [TIME_BITS-1:0]        reload_r    [MAX_TASKS];
  logic [TIME_BITS-1:0]        burst_r     [MAX_TASKS];
  logic [TIME_BITS-1:0]        countdown_r [MAX_TASKS];
  logic [edf_pkg::COUNT_W-1:0] lost_r      [MAX_TASKS];
  logic [edf_pkg::COUNT_W-1:0] done_r      [MAX_TASKS];

  // period and burst tables are undefined until written
  always_ff @(posedge clk) begin
    if (we.tables) begin
      period_r[addr] <= wr_period;
      reload_r[addr] <= wr_reload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        burst_r[i]     <= '0;
        countdown_r[i] <= '0;
        lost_r[i]      <= '0;
        done_r[i]      <= '0;
      end
    end else begin
      if (we.burst)     burst_r[addr]     <= wr_burst;
      if (we.countdown) countdown_r[addr] <= wr_countdown;
      if (we.lost)      lost_r[addr]      <= wr_lost;
      if (we.done)      done_r[addr]      <= wr_done;
    end
  end

  assign rd_period    = period_r[addr];
  assign rd_reload    = reload_r[addr];
  assign rd_burst     = burst_r[addr];
  assign rd_countdown = countdown_r[addr];
  assign rd_lost      = lost_r[addr];
  assign rd_done      = done_r[addr];

endmodule

// File: design/edf_slot_alu.sv
// Shared slot unit: release, deadline compare and countdown step for one slot
module edf_slot_alu #(
  parameter int TIME_BITS = 16
) (
  input  logic                 past_first,
  input  logic [TIME_BITS-1:0] burst,
  input  logic [TIME_BITS-1:0] countdown,
  input  logic [TIME_BITS-1:0] period,
  input  logic [TIME_BITS-1:0] reload,
  input  logic                 found,
  input  logic [TIME_BITS-1:0] best_dl,
  output logic [TIME_BITS-1:0] burst_out,
  output logic [TIME_BITS-1:0] countdown_sel,
  output logic [TIME_BITS-1:0] countdown_out,
  output logic                 lost,
  output logic                 better
);

  logic released;

  always_comb begin
    released      = past_first && (countdown == '0);
    burst_out     = released ? reload : burst;
    countdown_sel = released ? period : countdown;
    lost          = released && (burst != '0);
    better        = (burst_out != '0) && (!found || (countdown_sel < best_dl));
    countdown_out = (countdown_sel != '0) ? countdown_sel - 1'b1 : countdown_sel;
  end

endmodule

// File: design/edf_chk.sv
// Port-level checker for the scheduler, bound to the top level
`include "edf_tick_scheduler_unit_assert.svh"

module edf_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [edf_pkg::SLOT_W-1:0]  out_run_slot,
  input logic                        out_idle,
  input logic                        out_finished
);

  `EDF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled beat dropped")
  `EDF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "taken while busy")
  `EDF_ASSERT_IMP(a_idle_clean, out_valid && out_idle, !out_finished && !(|out_run_slot), "idle beat")

endmodule

bind edf_tick_scheduler_unit edf_chk u_edf_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_run_slot (out_ch.run_slot),
  .out_idle     (out_ch.idle),
  .out_finished (out_ch.finished)
);

// File: verif/testbench.sv
// Self-checking testbench for the EDF tick scheduler: directed table, random traffic, steady run
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the block must ignore
  localparam logic [edf_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam int N_SLOTS        = 8;
  localparam int SETTLE_CYCLES  = 16;    // longer than a tick over 8 slots
  localparam int TAIL_CYCLES    = 30;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int SUB_PHASES     = 12;
  localparam int BEATS_PER_SUB  = 42;
  localparam int SOAK_TICKS     = 20;    // steady win / steady loss pattern
  localparam int MAX_REPORTS    = 40;

  // Results that can be read off at a glance
  localparam edf_pkg::result_t RES_NONE       = '0;
  localparam edf_pkg::result_t RES_IDLE       = '{idle: 1'b1, default: '0};
  localparam edf_pkg::result_t RES_FULL_BURST = '{burst_left: '1, default: '0};

  // Task counts per random sub-phase; the last few are drawn at random
  localparam logic [edf_pkg::CFG_W-1:0] COUNT_PLAN [SUB_PHASES] =
    '{4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'd8, 4'd3, 4'd12, 4'd8, 4'd2, 4'd7, 4'd6};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    logic [edf_pkg::REQ_W-1:0]        rq;
    logic [edf_pkg::SLOT_W-1:0]       slot;
    logic [edf_pkg::TIME_FIELD_W-1:0] period;
    logic [edf_pkg::TIME_FIELD_W-1:0] burst;
    logic [edf_pkg::CFG_W-1:0]        cfg_val;
    bit                               typed;
    edf_pkg::result_t                 want;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [edf_pkg::CFG_W-1:0] cfg_wdata;

  edf_in_if  in_ch();
  edf_out_if out_ch();

  edf_tick_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler state as the testbench tracks it
  // ---------------------------------------------------------------------------
  logic [edf_pkg::TIME_FIELD_W-1:0] tsk_period    [N_SLOTS];
  logic [edf_pkg::TIME_FIELD_W-1:0] tsk_reload    [N_SLOTS];
  logic [edf_pkg::COUNT_W-1:0]      tsk_left      [N_SLOTS];
  logic [edf_pkg::COUNT_W-1:0]      tsk_countdown [N_SLOTS];
  logic [edf_pkg::COUNT_W-1:0]      tsk_lost      [N_SLOTS];
  logic [edf_pkg::COUNT_W-1:0]      tsk_done      [N_SLOTS];
  logic [edf_pkg::SLOT_W-1:0]       last_ran;
  bit                               ticked_once;
  logic [edf_pkg::CFG_W-1:0]        slots_cfg;

  plan_row_t        plan[$];
  edf_pkg::result_t pending_results[$];   // schedule results still owed by the block

  edf_pkg::result_t got_res, want_res;
  int      errors, reports, beats_in, beats_out, cfg_writes;
  int      ticks_seen, idle_seen, lost_seen;
  int      snd_idle_pct, rcv_idle_pct;
  int      hold_left, quiet_cycles;

  function automatic logic [edf_pkg::COUNT_W-1:0] bump(input logic [edf_pkg::COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the tracked state by one request beat and return its result
  function automatic edf_pkg::result_t schedule_step(
      input logic [edf_pkg::REQ_W-1:0]        rq,
      input logic [edf_pkg::SLOT_W-1:0]       slot,
      input logic [edf_pkg::TIME_FIELD_W-1:0] per,
      input logic [edf_pkg::TIME_FIELD_W-1:0] bst);
    edf_pkg::result_t            r;
    int                          n, q, best, j;
    bit                          found;
    logic [edf_pkg::COUNT_W-1:0] best_dl;
    r       = '0;
    found   = 1'b0;
    best    = 0;
    best_dl = '0;
    n       = (slots_cfg > N_SLOTS) ? N_SLOTS : int'(slots_cfg);
    case (rq)
      edf_pkg::REQ_WRITE: begin
        // zero period is held as one; counters survive a rewrite
        tsk_period[slot]    = (per == '0) ? 16'd1 : per;
        tsk_reload[slot]    = bst;
        tsk_left[slot]      = bst;
        tsk_countdown[slot] = (per == '0) ? 16'd1 : per;
      end
      edf_pkg::REQ_TICK: begin
        ticks_seen++;
        // release each slot in use at its period boundary, from the second tick on
        if (ticked_once) begin
          for (j = 0; j < n; j++) begin
            if (tsk_countdown[j] == '0) begin
              if (tsk_left[j] != '0) begin
                tsk_lost[j]    = bump(tsk_lost[j]);
                r.lost_mask[j] = 1'b1;
                lost_seen++;
              end
              tsk_left[j]      = tsk_reload[j];
              tsk_countdown[j] = tsk_period[j];
            end
          end
        end
        // earliest boundary wins; ties to the first met from the last slot run
        q = (int'(last_ran) < n) ? int'(last_ran) : 0;
        for (j = 0; j < n; j++) begin
          if (tsk_left[q] != '0 && (!found || tsk_countdown[q] < best_dl)) begin
            found   = 1'b1;
            best    = q;
            best_dl = tsk_countdown[q];
          end
          q = (q + 1 >= n) ? 0 : q + 1;
        end
        if (found) begin
          last_ran       = best[edf_pkg::SLOT_W-1:0];
          tsk_left[best] = tsk_left[best] - 1'b1;
          r.run_slot     = best[edf_pkg::SLOT_W-1:0];
          if (tsk_left[best] == '0) begin
            tsk_done[best] = bump(tsk_done[best]);
            r.finished     = 1'b1;
          end
        end else begin
          r.idle = 1'b1;
          idle_seen++;
        end
        for (j = 0; j < n; j++) begin
          if (tsk_countdown[j] != '0)
            tsk_countdown[j] = tsk_countdown[j] - 1'b1;
        end
        ticked_once = 1'b1;
      end
      edf_pkg::REQ_READ: begin
        r.lost_total = tsk_lost[slot];
        r.done_total = tsk_done[slot];
        r.burst_left = tsk_left[slot];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string show(input edf_pkg::result_t r);
    return $sformatf("slot=%0d idle=%0b fin=%0b lost_mask=%02h lost=%0d done=%0d left=%0d",
                     r.run_slot, r.idle, r.finished, r.lost_mask,
                     r.lost_total, r.done_total, r.burst_left);
  endfunction

  // Count every fault, print only the first few so a broken run stays readable
  function automatic void note_fault(input string what);
    errors++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("%0t: %s", $time, what);
    end
  endfunction

  function automatic void plan_beat(input logic [edf_pkg::REQ_W-1:0]        rq,
                                    input logic [edf_pkg::SLOT_W-1:0]       slot,
                                    input logic [edf_pkg::TIME_FIELD_W-1:0] per,
                                    input logic [edf_pkg::TIME_FIELD_W-1:0] bst,
                                    input bit                               typed = 1'b0,
                                    input edf_pkg::result_t                 want  = '0);
    plan_row_t row;
    row.kind    = ROW_REQ;
    row.rq      = rq;
    row.slot    = slot;
    row.period  = per;
    row.burst   = bst;
    row.cfg_val = '0;
    row.typed   = typed;
    row.want    = want;
    plan.push_back(row);
  endfunction

  function automatic void plan_count(input logic [edf_pkg::CFG_W-1:0] v);
    plan_row_t row;
    row         = '{kind: ROW_CFG, want: RES_NONE, default: '0};
    row.cfg_val = v;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. valid is left high after a beat so that back-to-back beats
  // need one assignment per step; anything that stops sending lowers it.
  // ---------------------------------------------------------------------------
  task automatic offer_beat(input logic [edf_pkg::REQ_W-1:0]        rq,
                            input logic [edf_pkg::SLOT_W-1:0]       slot,
                            input logic [edf_pkg::TIME_FIELD_W-1:0] per,
                            input logic [edf_pkg::TIME_FIELD_W-1:0] bst,
                            input bit                               typed,
                            input edf_pkg::result_t                 want);
    edf_pkg::result_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rq;
    in_ch.task_slot   <= slot;
    in_ch.task_period <= per;
    in_ch.task_burst  <= bst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // beat taken at this edge
    predicted = schedule_step(rq, slot, per, bst);
    pending_results.push_back(typed ? want : predicted);
    beats_in++;
  endtask

  // Wait until every owed result is back and the block has gone quiet
  task automatic settle;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [edf_pkg::CFG_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slots_cfg  = v;
    cfg_writes++;
  endtask

  // Mostly ticks over short periods and bursts so deadlines come round often;
  // one write in ten takes full-width values
  task automatic random_beat;
    int                               pick;
    logic [edf_pkg::REQ_W-1:0]        rq;
    logic [edf_pkg::SLOT_W-1:0]       slot;
    logic [edf_pkg::TIME_FIELD_W-1:0] per, bst;
    pick = $urandom_range(0, 99);
    slot = $urandom_range(0, N_SLOTS - 1);
    if (pick < 58)      rq = edf_pkg::REQ_TICK;
    else if (pick < 78) rq = edf_pkg::REQ_WRITE;
    else if (pick < 95) rq = edf_pkg::REQ_READ;
    else                rq = REQ_UNKNOWN;
    if ($urandom_range(0, 9) == 0) begin
      per = $urandom_range(0, 16'hFFFF);
      bst = $urandom_range(0, 16'hFFFF);
    end else begin
      per = $urandom_range(0, 12);
      bst = $urandom_range(0, 6);
    end
    offer_beat(rq, slot, per, bst, 1'b0, RES_NONE);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each beat against the oldest expectation, then pick the
  // next ready. Two long hold-offs let the block back up into its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      beats_out++;
      if (beats_out == 120 || beats_out == 400)
        hold_left = HOLD_CYCLES;
      got_res = {out_ch.run_slot, out_ch.idle, out_ch.finished, out_ch.lost_mask,
                 out_ch.lost_total, out_ch.done_total, out_ch.burst_left};
      if (pending_results.size() == 0) begin
        note_fault($sformatf("result beat with nothing expected: %s", show(got_res)));
      end else begin
        want_res = pending_results.pop_front();
        if (got_res !== want_res)
          note_fault($sformatf("mismatch on result beat %0d\n  expected %s\n  actual   %s",
                               beats_out, show(want_res), show(got_res)));
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Watchdog: too long without a beat on either channel ends the run
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results still owed",
                 $time, quiet_cycles, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int                        sub, k;
    logic [edf_pkg::CFG_W-1:0] next_count;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= edf_pkg::REQ_WRITE;
    in_ch.task_slot   <= '0;
    in_ch.task_period <= '0;
    in_ch.task_burst  <= '0;

    errors = 0; reports = 0; beats_in = 0; beats_out = 0; cfg_writes = 0;
    ticks_seen = 0; idle_seen = 0; lost_seen = 0;
    hold_left = 0; quiet_cycles = 0;

    // tracked state as reset leaves it
    for (k = 0; k < N_SLOTS; k++) begin
      tsk_period[k]    = '0;
      tsk_reload[k]    = '0;
      tsk_left[k]      = '0;
      tsk_countdown[k] = '0;
      tsk_lost[k]      = '0;
      tsk_done[k]      = '0;
    end
    last_ran    = '0;
    ticked_once = 1'b0;
    slots_cfg   = 4'd1;

    // first third: sender mostly busy, receiver mostly stalling
    snd_idle_pct = 10;
    rcv_idle_pct = 77;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The lone tick straight after reset is safe with slot 0
    // unwritten, as nothing is released on the first tick; every slot is
    // written before the next tick and stays written for the rest of the run.
    plan_beat(edf_pkg::REQ_READ,  3'd0, 16'h0000, 16'h0000, 1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_TICK,  3'd7, 16'hFFFF, 16'hFFFF, 1'b1, RES_IDLE);
    plan_beat(REQ_UNKNOWN,        3'd7, 16'hFFFF, 16'hFFFF, 1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_WRITE, 3'd0, 16'd0,    16'd2,    1'b1, RES_NONE); // period 0 -> 1
    plan_beat(edf_pkg::REQ_WRITE, 3'd1, 16'hFFFF, 16'hFFFF, 1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_WRITE, 3'd2, 16'd3,    16'd1,    1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_WRITE, 3'd3, 16'd1,    16'd0,    1'b1, RES_NONE); // empty burst
    plan_beat(edf_pkg::REQ_WRITE, 3'd4, 16'd4,    16'd2,    1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_WRITE, 3'd5, 16'd6,    16'd3,    1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_WRITE, 3'd6, 16'd2,    16'd1,    1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_WRITE, 3'd7, 16'd8,    16'd0,    1'b1, RES_NONE);
    plan_beat(edf_pkg::REQ_READ,  3'd1, 16'h0000, 16'h0000, 1'b1, RES_FULL_BURST);
    plan_count(4'd15);                                // saturates to all 8 slots
    for (k = 0; k < 6; k++)
      plan_beat(edf_pkg::REQ_TICK, 3'd0, 16'h0000, 16'h0000);
    plan_beat(edf_pkg::REQ_READ,  3'd0, 16'h0000, 16'h0000);
    plan_count(4'd0);                                 // no slot in use
    plan_beat(edf_pkg::REQ_TICK,  3'd0, 16'h0000, 16'h0000, 1'b1, RES_IDLE);
    plan_count(4'd3);
    plan_beat(edf_pkg::REQ_TICK,  3'd0, 16'h0000, 16'h0000);
    plan_beat(edf_pkg::REQ_TICK,  3'd0, 16'h0000, 16'h0000);
    plan_beat(edf_pkg::REQ_READ,  3'd7, 16'h0000, 16'h0000);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_count(plan[i].cfg_val);
      else
        offer_beat(plan[i].rq, plan[i].slot, plan[i].period, plan[i].burst,
                   plan[i].typed, plan[i].want);
    end

    // Random traffic in sub-phases, each under its own task count. Shrinking
    // the count below the last slot run sends the scan back to slot 0.
    for (sub = 0; sub < SUB_PHASES; sub++) begin
      if (sub == SUB_PHASES / 3) begin
        snd_idle_pct = 77;
        rcv_idle_pct = 10;
      end
      if (sub == 2 * SUB_PHASES / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      next_count = (sub >= 9) ? 4'($urandom_range(0, 15)) : COUNT_PLAN[sub];
      write_count(next_count);
      repeat (BEATS_PER_SUB) random_beat();
    end

    // Steady run: slot 0 (period 1, burst 1) wins every tick and finishes,
    // slot 1 (period 1, burst 2) loses a deadline on every tick after the first.
    // A tick at one slot first makes slot 0 the last one run.
    write_count(4'd1);
    offer_beat(edf_pkg::REQ_WRITE, 3'd0, 16'd1, 16'd1, 1'b1, RES_NONE);
    offer_beat(edf_pkg::REQ_TICK,  3'd0, 16'd0, 16'd0, 1'b0, RES_NONE);
    write_count(4'd2);
    offer_beat(edf_pkg::REQ_WRITE, 3'd1, 16'd1, 16'd2, 1'b1, RES_NONE);
    offer_beat(edf_pkg::REQ_WRITE, 3'd0, 16'd1, 16'd1, 1'b1, RES_NONE);
    repeat (SOAK_TICKS)
      offer_beat(edf_pkg::REQ_TICK, 3'd0, 16'd0, 16'd0, 1'b0, RES_NONE);
    offer_beat(edf_pkg::REQ_READ, 3'd0, 16'd0, 16'd0, 1'b0, RES_NONE);
    offer_beat(edf_pkg::REQ_READ, 3'd1, 16'd0, 16'd0, 1'b0, RES_NONE);

    // drain; the watchdog catches results that never come
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d request beats and %0d result beats under %0d task-count settings.",
             beats_in, beats_out, cfg_writes);
    $display("Ticks %0d (idle %0d), lost-deadline events %0d; %0d faults.",
             ticks_seen, idle_seen, lost_seen, errors);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
